// File: hdl/wlos_pkg.sv
package wlos_pkg;

	// Defaults of the top-level parameters.
	localparam int NUM_WEIGHTS_DEF = 68;
	localparam int COUNT_BITS_DEF  = 31;
	localparam int FRAC_BITS_DEF   = 16;

	// Fixed widths of the record counters and the running sum.
	localparam int POS_W   = 7;
	localparam int ACC_W   = 27;
	localparam logic [POS_W-1:0] POS_MAX        = 7'd127;
	localparam logic [POS_W-1:0] EXPECTED_RESET = 7'd68;
	localparam logic [ACC_W-1:0] ACC_MAX        = 27'd134217727;

	// Weights are unsigned Q1.16.
	localparam int WEIGHT_W    = 17;
	localparam int WEIGHT_FRAC = 16;

	// The log mantissa is held in Q1.30.
	localparam int MANT_W = 31;

	// ln(2) scaled by 2^32, rounded to nearest.
	localparam int LN2_W = 32;
	localparam logic [LN2_W-1:0] LN2_Q32 = 32'd2977044472;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	// Orbit sizes for orbits 1 to 68 (orbit 0 is skipped).
	localparam int ORBIT_ROM_LEN = 68;
	localparam logic [2:0] ORBIT_SIZE_ROM [ORBIT_ROM_LEN] = '{
		3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4,
		3'd3, 3'd3, 3'd4, 3'd5, 3'd4, 3'd5, 3'd5, 3'd4, 3'd5, 3'd6,
		3'd6, 3'd4, 3'd5, 3'd6, 3'd4, 3'd5, 3'd6, 3'd4, 3'd5, 3'd5,
		3'd5, 3'd6, 3'd5, 3'd6, 3'd6, 3'd7, 3'd4, 3'd6, 3'd5, 3'd6,
		3'd5, 3'd7, 3'd5, 3'd5, 3'd6, 3'd7, 3'd6, 3'd6, 3'd4, 3'd4,
		3'd6, 3'd5, 3'd7, 3'd7, 3'd7, 3'd6, 3'd5, 3'd7, 3'd5, 3'd6,
		3'd7, 3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6, 3'd4
	};

	// Weight 1 - ln(s)/ln(68) in Q1.16, indexed by orbit size s.
	localparam logic [WEIGHT_W-1:0] WEIGHT_BY_SIZE [8] = '{
		17'd0, 17'd65536, 17'd54770, 17'd48473,
		17'd44005, 17'd40539, 17'd37707, 17'd35313
	};

	// Control information that travels with each log value to the back.
	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic                last;
		logic [POS_W-1:0]    seen;
	} ctl_t;

	// Width of the normalising word: the incremented count, at least the mantissa.
	function automatic int norm_width(input int count_bits);
		return (count_bits + 1 > MANT_W) ? count_bits + 1 : MANT_W;
	endfunction

	// Width of the log value: exponent bits and fraction bits.
	function automatic int ln_width(input int count_bits, input int frac_bits);
		return $clog2(norm_width(count_bits)) + frac_bits;
	endfunction

	// Weight of a record position, zero beyond the end of the orbit table.
	function automatic logic [WEIGHT_W-1:0] orbit_weight(input logic [POS_W-1:0] k);
		logic [WEIGHT_W-1:0] w;
		w = '0;
		if (k < POS_W'(ORBIT_ROM_LEN)) begin
			w = WEIGHT_BY_SIZE[ORBIT_SIZE_ROM[k]];
		end
		return w;
	endfunction

endpackage

// File: hdl/weighted_log_orbit_sum.sv
// Weighted log sum over one record of edge orbit counts.
// Input channel: orbit_count and last are offered with push and taken at a clock
// edge where push is high and full is low; last closes the record.
// Result channel: while empty is low, weighted_sum (unsigned Q11.16, saturated),
// record_ok and counts_seen show the oldest result; pop takes it.
// Configuration: cfg_we writes cfg_wdata into the expected record length at once.
// Each count occupies the log unit for a binary leading-zero search, one mantissa
// squaring a cycle on the 31 by 31 bit multiplier, and the ln scaling; full is high
// meanwhile. A two-entry queue lets the accumulating back end run on its own; a
// result appears once the log value of the closing count has passed from the queue
// through stage one into the result register.
// When the receiver stalls, the result waits in its register and the front end keeps
// taking counts until the queue is full.
// Reset clears the record position, the sum, the queue and the result register and
// sets the expected length to 68.
module weighted_log_orbit_sum #(
	parameter int NUM_WEIGHTS = wlos_pkg::NUM_WEIGHTS_DEF,
	parameter int COUNT_BITS  = wlos_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS   = wlos_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [COUNT_BITS-1:0]          orbit_count,
	input  logic                           last,
	output logic                           empty,
	input  logic                           pop,
	output logic [wlos_pkg::ACC_W-1:0]     weighted_sum,
	output logic                           record_ok,
	output logic [wlos_pkg::POS_W-1:0]     counts_seen,
	input  logic                           cfg_we,
	input  logic [wlos_pkg::POS_W-1:0]     cfg_wdata
);

	localparam int LNW = wlos_pkg::ln_width(COUNT_BITS, FRAC_BITS);
	localparam int CTW = $bits(wlos_pkg::ctl_t);
	localparam int QW  = CTW + LNW;

	logic [wlos_pkg::POS_W-1:0] expected_count_q;

	logic           fq_push;
	logic           fq_full;
	wlos_pkg::ctl_t fq_ctl;
	logic [LNW-1:0] fq_ln;
	logic           bq_pop;
	logic           bq_empty;
	logic [QW-1:0]  bq_data;
	wlos_pkg::ctl_t bq_ctl;
	logic [LNW-1:0] bq_ln;

	// Expected record length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_count_q <= wlos_pkg::EXPECTED_RESET;
		end else if (cfg_we) begin
			expected_count_q <= cfg_wdata;
		end
	end

	assign bq_ctl = wlos_pkg::ctl_t'(bq_data[QW-1:LNW]);
	assign bq_ln  = bq_data[LNW-1:0];

	wlos_front #(
		.NUM_WEIGHTS (NUM_WEIGHTS),
		.COUNT_BITS  (COUNT_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.orbit_count (orbit_count),
		.last        (last),
		.q_push      (fq_push),
		.q_full      (fq_full),
		.q_ctl       (fq_ctl),
		.q_ln        (fq_ln)
	);

	wlos_fifo #(
		.WIDTH (QW),
		.DEPTH (wlos_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.full   (fq_full),
		.wdata  ({fq_ctl, fq_ln}),
		.pop    (bq_pop),
		.empty  (bq_empty),
		.rdata  (bq_data)
	);

	wlos_back #(
		.LNW (LNW)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (bq_empty),
		.q_pop          (bq_pop),
		.q_ctl          (bq_ctl),
		.q_ln           (bq_ln),
		.expected_count (expected_count_q),
		.empty          (empty),
		.pop            (pop),
		.weighted_sum   (weighted_sum),
		.record_ok      (record_ok),
		.counts_seen    (counts_seen)
	);

endmodule

// File: hdl/wlos_front.sv
module wlos_front #(
	parameter int NUM_WEIGHTS = wlos_pkg::NUM_WEIGHTS_DEF,
	parameter int COUNT_BITS  = wlos_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS   = wlos_pkg::FRAC_BITS_DEF,
	localparam int LNW        = wlos_pkg::ln_width(COUNT_BITS, FRAC_BITS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [COUNT_BITS-1:0] orbit_count,
	input  logic                  last,
	output logic                  q_push,
	input  logic                  q_full,
	output wlos_pkg::ctl_t        q_ctl,
	output logic [LNW-1:0]        q_ln
);

	localparam int NW   = wlos_pkg::norm_width(COUNT_BITS);
	localparam int SW   = $clog2(NW);
	localparam int MW   = wlos_pkg::MANT_W;
	localparam int CMAX = (SW > FRAC_BITS) ? SW : FRAC_BITS;
	localparam int CW   = $clog2(CMAX + 1);
	localparam int PW   = LNW + wlos_pkg::LN2_W;
	localparam int PSW  = wlos_pkg::POS_W;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_NORM   = 4'b0010,
		ST_SQUARE = 4'b0100,
		ST_DONE   = 4'b1000
	} fst_t;

	fst_t                 state_q;
	logic [PSW-1:0]       pos_q;
	logic [CW-1:0]        cnt_q;
	wlos_pkg::ctl_t       ctl_q;
	logic [NW-1:0]        norm_q;
	logic [SW-1:0]        shift_q;
	logic [SW-1:0]        e_q;
	logic [MW-1:0]        m_q;
	logic [FRAC_BITS-1:0] frac_q;

	logic [COUNT_BITS:0]              count_p1;
	logic [PSW-1:0]                   pos_nx;
	logic [wlos_pkg::WEIGHT_W-1:0]    weight;
	logic [SW-1:0]                    amt;
	logic [NW-1:0]                    top_mask;
	logic                             take;
	logic [NW-1:0]                    norm_nx;
	logic [SW-1:0]                    shift_nx;
	logic [SW-1:0]                    e_nx;
	logic [2*MW-1:0]                  sq;
	logic [MW:0]                      sq_hi;
	logic [MW-1:0]                    m_nx;
	logic [PW-1:0]                    prod;

	// Handshake: a new transaction is taken only while the log unit is free.
	assign full   = (state_q != ST_IDLE);
	assign q_push = (state_q == ST_DONE);
	assign q_ctl  = ctl_q;

	// Classification of the incoming count: position, weight and operand.
	always_comb begin
		count_p1 = {1'b0, orbit_count} + (COUNT_BITS + 1)'(1);
		pos_nx   = (pos_q == wlos_pkg::POS_MAX) ? pos_q : pos_q + PSW'(1);
		weight   = '0;
		if ({1'b0, pos_q} < (PSW + 1)'(NUM_WEIGHTS)) begin
			weight = wlos_pkg::orbit_weight(pos_q);
		end
	end

	// One step of the leading-zero search, halving the shift each cycle.
	always_comb begin
		amt      = SW'(1) << cnt_q;
		top_mask = ~({NW{1'b1}} >> amt);
		take     = ((norm_q & top_mask) == '0);
		norm_nx  = take ? (norm_q << amt) : norm_q;
		shift_nx = take ? (shift_q + amt) : shift_q;
		e_nx     = SW'(NW - 1) - shift_nx;
	end

	// One squaring of the mantissa yields one fraction bit of log2.
	always_comb begin
		sq    = (2*MW)'(m_q) * (2*MW)'(m_q);
		sq_hi = sq[2*MW-1:MW-1];
		m_nx  = sq_hi[MW] ? sq_hi[MW:1] : sq_hi[MW-1:0];
	end

	// Conversion of log2 to ln; the queue entry registers the product.
	always_comb begin
		prod = PW'({e_q, frac_q}) * PW'(wlos_pkg::LN2_Q32);
		q_ln = prod[PW-1:wlos_pkg::LN2_W];
	end

	// Sequencer and record position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (push) begin
						pos_q   <= last ? '0 : pos_nx;
						cnt_q   <= CW'(SW - 1);
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (cnt_q == '0) begin
						cnt_q   <= CW'(FRAC_BITS - 1);
						state_q <= ST_SQUARE;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_SQUARE: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_DONE: begin
					if (!q_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the log unit.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (push) begin
					norm_q      <= NW'(count_p1);
					shift_q     <= '0;
					ctl_q.weight <= weight;
					ctl_q.last   <= last;
					ctl_q.seen   <= pos_nx;
				end
			end
			ST_NORM: begin
				norm_q  <= norm_nx;
				shift_q <= shift_nx;
				if (cnt_q == '0) begin
					m_q    <= norm_nx[NW-1 -: MW];
					e_q    <= e_nx;
					frac_q <= '0;
				end
			end
			ST_SQUARE: begin
				m_q    <= m_nx;
				frac_q <= {frac_q[FRAC_BITS-2:0], sq_hi[MW]};
			end
			default: begin
			end
		endcase
	end

endmodule

// File: hdl/wlos_fifo.sv
module wlos_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = wlos_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      fill_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (fill_q == (AW + 1)'(DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + (AW + 1)'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - (AW + 1)'(1);
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: hdl/wlos_back.sv
module wlos_back #(
	parameter int LNW = 21
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	output logic                           q_pop,
	input  wlos_pkg::ctl_t                 q_ctl,
	input  logic [LNW-1:0]                 q_ln,
	input  logic [wlos_pkg::POS_W-1:0]     expected_count,
	output logic                           empty,
	input  logic                           pop,
	output logic [wlos_pkg::ACC_W-1:0]     weighted_sum,
	output logic                           record_ok,
	output logic [wlos_pkg::POS_W-1:0]     counts_seen
);

	localparam int AW   = wlos_pkg::ACC_W;
	localparam int PSW  = wlos_pkg::POS_W;
	localparam int MPW  = wlos_pkg::WEIGHT_W + LNW;
	localparam int SUMW = ((AW > LNW) ? AW : LNW) + 1;

	logic           v_s1;
	logic [LNW-1:0] term_s1;
	logic           last_s1;
	logic [PSW-1:0] seen_s1;

	logic [AW-1:0]  acc_q;
	logic           out_valid_q;
	logic [AW-1:0]  out_sum_q;
	logic           out_ok_q;
	logic [PSW-1:0] out_seen_q;

	logic [MPW-1:0]  wprod;
	logic [SUMW-1:0] sum;
	logic [AW-1:0]   sum_sat;
	logic            adv;

	assign empty        = !out_valid_q;
	assign weighted_sum = out_sum_q;
	assign record_ok    = out_ok_q;
	assign counts_seen  = out_seen_q;

	// Stage one moves on unless it closes a record and the result register holds a result that is not being taken.
	assign adv   = v_s1 && (!last_s1 || !out_valid_q || pop);
	assign q_pop = !q_empty && (!v_s1 || adv);

	// Weighted term and saturating sum.
	always_comb begin
		wprod   = MPW'(q_ctl.weight) * MPW'(q_ln);
		sum     = SUMW'(acc_q) + SUMW'(term_s1);
		sum_sat = (sum > SUMW'(wlos_pkg::ACC_MAX)) ? wlos_pkg::ACC_MAX : sum[AW-1:0];
	end

	// Control state of the back end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				acc_q <= last_s1 ? '0 : sum_sat;
			end
			if (adv && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload of stage one and of the result register.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			term_s1 <= wprod[wlos_pkg::WEIGHT_FRAC +: LNW];
			last_s1 <= q_ctl.last;
			seen_s1 <= q_ctl.seen;
		end
		if (adv && last_s1) begin
			out_sum_q  <= sum_sat;
			out_ok_q   <= (seen_s1 == expected_count);
			out_seen_q <= seen_s1;
		end
	end

endmodule

// File: hdl/wlos_checker.sv
module wlos_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       push,
	input logic                       full,
	input logic                       empty,
	input logic                       pop,
	input logic [wlos_pkg::ACC_W-1:0] weighted_sum,
	input logic                       record_ok,
	input logic [wlos_pkg::POS_W-1:0] counts_seen
);

	// An accepted count keeps the log unit busy, with full high after it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> (full ##1 full))
		else $error("input taken again too soon after a transaction");

	// Every result closes a record that holds at least one count.
	a_seen_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (counts_seen != '0))
		else $error("result reports an empty record");

	// A waiting result stays until it is taken.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result withdrawn before its transaction");

	// A waiting result does not change until it is taken.
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=>
		($stable(weighted_sum) && $stable(record_ok) && $stable(counts_seen)))
		else $error("result changed while waiting");

endmodule

bind weighted_log_orbit_sum wlos_checker u_chk (.*);
